/* rtl/lips_pkg.sv */
// ----------------------------------------------------------------------------
// lips_pkg: shared types and constants for the Lorentz inner product search
// Sizes of the stores, register indexes, sequencer states and helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package lips_pkg;
  localparam int MAX_ENTRIES = 1024;
  localparam int MAX_LENGTH  = 64;
  localparam int MAX_RESULTS = 16;
  localparam int EW  = $clog2(MAX_ENTRIES);     // entry index width
  localparam int CW  = $clog2(MAX_ENTRIES + 1); // entry count width
  localparam int LW  = $clog2(MAX_LENGTH);      // coordinate index width
  localparam int PW  = $clog2(MAX_LENGTH + 1);  // coordinate position width
  localparam int RW  = $clog2(MAX_RESULTS);     // result slot index width
  localparam int KW  = $clog2(MAX_RESULTS + 1); // result count width

  localparam logic REG_VECTOR_LENGTH = 1'b0;
  localparam logic REG_RESULT_COUNT  = 1'b1;
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_MAC, ST_DRAIN, ST_INSERT, ST_EMIT
  } state_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (a[63] && b[63] && !s[63]) return 64'sh8000_0000_0000_0000;
    return s;
  endfunction
endpackage
`default_nettype wire

/* rtl/lips_mac.sv */
// ----------------------------------------------------------------------------
// lips_mac: shared multiply-accumulate unit
// One 32x32 signed product per cycle, registered, then a saturating add.
// ----------------------------------------------------------------------------
`default_nettype none
module lips_mac (
  input  wire logic               clk,
  input  wire logic               clear,
  input  wire logic               prod_en,
  input  wire logic               negate,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      acc
);
  import lips_pkg::*;
  logic signed [63:0] prod_r;
  logic               prod_vld_r;
  logic               neg_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] term;

  // the negated time term is exact: -(2^31*2^31 ... ) never reaches -2^63
  assign term = neg_r ? -prod_r : prod_r;

  always_ff @(posedge clk) begin
    prod_r     <= a * b;
    neg_r      <= negate;
    prod_vld_r <= prod_en;
    if (clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= neg_r ? term : sat_add(acc_r, term);
    end
  end
  assign acc = acc_r;
endmodule
`default_nettype wire

/* rtl/lorentz_inner_product_top_k_search.sv */
`default_nettype none
// Adds and non-final query coordinates are taken one per cycle, busy stays low. A final
// query coordinate holds busy while the shared MAC scans the store: each entry's tag is
// checked, and each entry that passes the scope filter gets a MAC pass, pipeline drain
// and sorted insert; then the results come on a strobe and cannot be stalled.
// Reset: synchronous, active low; clears entry count, position and mode, sets registers
// to vector_length 64 and result_count 8; stores stay unset.
// ----------------------------------------------------------------------------
// lorentz_inner_product_top_k_search: brute force top-k Lorentz search
// Vector store, sequencer and sorted best list around one shared MAC.
// ----------------------------------------------------------------------------
module lorentz_inner_product_top_k_search (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_coordinate,
  input  wire logic        in_last_coordinate,
  input  wire logic [30:0] in_chunk_id,
  input  wire logic [15:0] in_scope_tag,
  input  wire logic        in_scope_enable,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data,
  output logic             out_valid,
  output logic             out_found,
  output logic [30:0]      out_result_chunk_id,
  output logic [15:0]      out_result_tag,
  output logic [63:0]      out_score,
  output logic             out_last_result
);
  import lips_pkg::*;

  logic [6:0] vlen_r;
  logic [4:0] rcnt_r;
  logic [CW-1:0] count_r;
  logic [PW-1:0] pos_r;
  logic mode_r;
  state_t state_r, state_nxt;

  // memories
  logic signed [31:0] vmem [MAX_ENTRIES*MAX_LENGTH];
  logic [30:0] idmem [MAX_ENTRIES];
  logic [15:0] tagmem [MAX_ENTRIES];
  logic signed [31:0] qbuf [MAX_LENGTH];
  logic [LW:0] qlen_r; // coordinates actually written into the query

  logic signed [31:0] vrd_r, qrd_r;
  logic [15:0] tagrd_r;
  logic [30:0] idrd_r;

  logic [PW-1:0] len;
  logic [KW-1:0] keff;
  always_comb begin
    len = (vlen_r < 7'd2) ? PW'(2) :
          (vlen_r > 7'(MAX_LENGTH)) ? PW'(MAX_LENGTH) : PW'(vlen_r);
    keff = (rcnt_r == 5'd0) ? KW'(1) :
           (rcnt_r > 5'(MAX_RESULTS)) ? KW'(MAX_RESULTS) : KW'(rcnt_r);
  end

  // scan state
  logic [EW-1:0] ent_r;       // entry under test
  logic [PW-1:0] j_r;         // coordinate index issued
  logic [1:0]    drain_r;
  logic          scoped_r;
  logic [15:0]   qtag_r;
  logic signed [63:0] bs_r [MAX_RESULTS];
  logic [EW-1:0]      bi_r [MAX_RESULTS];
  logic [KW-1:0] n_r;
  logic [RW:0]   p_r;         // insert search / emit index
  logic [EW-1:0] emit_idx;
  logic emit_rd_r;            // id/tag read issued for emission
  logic chk_wait_r;           // tag read for the current entry still in flight
  logic signed [63:0] acc;

  logic accept;
  assign busy = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign cfg_ready = !busy;

  logic mac_clear, mac_en, mac_neg;
  logic [LW-1:0] j_idx;
  assign j_idx = j_r[LW-1:0];

  lips_mac u_mac (
    .clk(clk), .clear(mac_clear), .prod_en(mac_en), .negate(mac_neg),
    .a(qrd_r), .b(vrd_r), .acc(acc)
  );

  logic mac_issue_r, mac_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vlen_r  <= 7'd64;
      rcnt_r  <= 5'd8;
      count_r <= '0;
      pos_r   <= '0;
      mode_r  <= OP_ADD;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_VECTOR_LENGTH: vlen_r <= cfg_data;
          REG_RESULT_COUNT:  rcnt_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (accept) begin
        mode_r <= in_operation;
        if (in_last_coordinate) begin
          pos_r <= '0;
          if (in_operation == OP_ADD && count_r < CW'(MAX_ENTRIES))
            count_r <= count_r + 1'b1;
        end else begin
          logic [PW-1:0] p0;
          p0 = (in_operation != mode_r) ? '0 : pos_r;
          pos_r <= (p0 < len) ? p0 + 1'b1 : p0;
        end
      end
    end
  end

  // store writes; rows are padded at read time by the written length
  logic [PW-1:0] cur_pos;
  assign cur_pos = (in_operation != mode_r) ? '0 : pos_r;
  logic [PW-1:0] add_len_r [MAX_ENTRIES];
  always_ff @(posedge clk) begin
    if (accept && cur_pos < len) begin
      if (in_operation == OP_QUERY) qbuf[cur_pos[LW-1:0]] <= in_coordinate;
      else if (count_r < CW'(MAX_ENTRIES))
        vmem[{count_r[EW-1:0], cur_pos[LW-1:0]}] <= in_coordinate;
    end
    if (accept && in_last_coordinate) begin
      if (in_operation == OP_QUERY) begin
        qlen_r   <= (cur_pos < len) ? (LW+1)'(cur_pos + 1'b1) : (LW+1)'(cur_pos);
        scoped_r <= in_scope_enable;
        qtag_r   <= in_scope_tag;
      end else if (count_r < CW'(MAX_ENTRIES)) begin
        idmem[count_r[EW-1:0]]  <= in_chunk_id;
        tagmem[count_r[EW-1:0]] <= in_scope_tag;
        add_len_r[count_r[EW-1:0]] <= (cur_pos < len) ? cur_pos + 1'b1 : cur_pos;
      end
    end
  end

  // registered reads
  logic [PW-1:0] rowlen_r;
  logic [EW-1:0] rd_ent;
  assign emit_idx = bi_r[p_r[RW-1:0]];
  assign rd_ent = (state_r == ST_EMIT || state_nxt == ST_EMIT) ? emit_idx : ent_r;
  always_ff @(posedge clk) begin
    vrd_r    <= (PW'(j_idx) < rowlen_r) ? vmem[{ent_r, j_idx}] : '0;
    qrd_r    <= ((LW+1)'(j_idx) < qlen_r) ? qbuf[j_idx] : '0;
    tagrd_r  <= tagmem[rd_ent];
    idrd_r   <= idmem[rd_ent];
    rowlen_r <= add_len_r[ent_r];
    mac_issue_r <= (state_r == ST_MAC);
    mac_neg_r   <= (state_r == ST_MAC) && (j_r == '0);
  end
  assign mac_en  = mac_issue_r;
  assign mac_neg = mac_neg_r;

  logic at_end;
  assign at_end = (CW'(ent_r) + 1'b1 >= count_r);

  always_comb begin
    state_nxt = state_r;
    mac_clear = 1'b0;
    unique case (state_r)
      ST_IDLE:   if (accept && in_operation == OP_QUERY && in_last_coordinate)
                   state_nxt = (count_r == '0) ? ST_EMIT : ST_CHECK;
      ST_CHECK:  if (!chk_wait_r)
                   state_nxt = (!scoped_r || tagrd_r == qtag_r) ? ST_MAC :
                               (at_end ? ST_EMIT : ST_CHECK);
      ST_MAC:    if (j_r + 1'b1 >= len) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (drain_r == 2'd3) state_nxt = ST_INSERT;
      ST_INSERT: if (p_r >= (RW+1)'(n_r) || bs_r[p_r[RW-1:0]] < acc)
                   state_nxt = at_end ? ST_EMIT : ST_CHECK;
      ST_EMIT:   if (emit_rd_r && (n_r == '0 || p_r + 1'b1 >= (RW+1)'(n_r)))
                   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer datapath; CHECK waits out chk_wait_r for the registered tag read to settle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0; j_r <= '0; drain_r <= '0; n_r <= '0; p_r <= '0;
      emit_rd_r <= 1'b0; chk_wait_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          ent_r <= '0; n_r <= '0; p_r <= '0; emit_rd_r <= 1'b0;
          chk_wait_r <= 1'b1;
        end
        ST_CHECK: begin
          j_r <= '0; drain_r <= '0;
          if (chk_wait_r) begin
            chk_wait_r <= 1'b0;
          end else if (state_nxt == ST_CHECK) begin
            ent_r <= ent_r + 1'b1; chk_wait_r <= 1'b1;
          end else if (state_nxt == ST_EMIT) begin
            p_r <= '0;
          end
        end
        ST_MAC:   j_r <= j_r + 1'b1;
        ST_DRAIN: begin drain_r <= drain_r + 1'b1; p_r <= '0; end
        ST_INSERT: begin
          if (state_nxt != ST_INSERT) begin
            if (p_r < (RW+1)'(keff)) begin
              for (int m = MAX_RESULTS - 1; m > 0; m--) begin
                if ((RW+1)'(m) > p_r) begin
                  bs_r[m] <= bs_r[m-1]; bi_r[m] <= bi_r[m-1];
                end
              end
              bs_r[p_r[RW-1:0]] <= acc;
              bi_r[p_r[RW-1:0]] <= ent_r;
              if (n_r < keff) n_r <= n_r + 1'b1;
            end
            ent_r <= ent_r + 1'b1; chk_wait_r <= 1'b1; p_r <= '0;
          end else begin
            p_r <= p_r + 1'b1;
          end
        end
        ST_EMIT: begin
          if (!emit_rd_r) begin
            emit_rd_r <= 1'b1;
          end else begin
            out_valid <= 1'b1;
            out_found <= (n_r != '0);
            out_result_chunk_id <= (n_r != '0) ? idrd_r : '0;
            out_result_tag      <= (n_r != '0) ? tagrd_r : '0;
            out_score <= (n_r != '0) ? bs_r[p_r[RW-1:0]] : '0;
            out_last_result <= (n_r == '0) || (p_r + 1'b1 >= (RW+1)'(n_r));
            p_r <= p_r + 1'b1;
            emit_rd_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* tb/sv/lorentz_inner_product_top_k_search_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lorentz_inner_product_top_k_search_tb: self-checking bench for the search
// Streams add and query vectors through the command port and rewrites both
// registers between phases. Each result transfer is compared with a scored,
// sorted top-k list from a behavioural copy of the store or a directed answer.
// ----------------------------------------------------------------------------
module lorentz_inner_product_top_k_search_tb;
  import lips_pkg::*;

  localparam int WATCHDOG = 400000;

  typedef struct packed {
    logic        op;
    logic [31:0] coord;
    logic        last;
    logic [30:0] chunk;
    logic [15:0] tag;
    logic        scoped;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [30:0] chunk;
    logic [15:0] tag;
    logic [63:0] score;
    logic        last;
  } answer_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    answer_t ans;
  } row_t;

  localparam answer_t EMPTY_ANS = '{1'b0, 31'd0, 16'd0, 64'd0, 1'b1};
  localparam answer_t NO_ANS    = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = OP_ADD;
  logic [31:0] in_coordinate = '0;
  logic in_last_coordinate = 1'b0;
  logic [30:0] in_chunk_id = '0;
  logic [15:0] in_scope_tag = '0;
  logic in_scope_enable = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_VECTOR_LENGTH;
  logic [6:0] cfg_data = '0;
  logic out_valid, out_found, out_last_result;
  logic [30:0] out_result_chunk_id;
  logic [15:0] out_result_tag;
  logic [63:0] out_score;

  lorentz_inner_product_top_k_search dut (.*);

  always #5 clk = ~clk;

  // behavioural copy of the store
  logic signed [31:0] row_mem [MAX_ENTRIES*MAX_LENGTH];
  logic [30:0] id_mem [MAX_ENTRIES];
  logic [15:0] tag_mem [MAX_ENTRIES];
  logic signed [31:0] qvec [MAX_LENGTH];
  int unsigned n_entries = 0, coord_pos = 0;
  logic in_query = 1'b0;
  logic [6:0] len_reg = 7'd64;
  logic [4:0] k_reg = 5'd8;

  answer_t pending_q[$];
  int errors = 0, n_items = 0, n_queries = 0, n_answers = 0, idle_pct = 0;
  int quiet = 0;

  function automatic longint sat_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a >= 0 && b >= 0 && s < 0) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
    return s;
  endfunction

  function automatic void rank_query(input item_t it, ref answer_t res[$]);
    int unsigned len, k, pos, n, p, m, base;
    longint acc;
    longint best_s [MAX_RESULTS];
    int unsigned best_i [MAX_RESULTS];
    answer_t a;
    res.delete();
    len = (len_reg < 2) ? 2 : (len_reg > MAX_LENGTH) ? MAX_LENGTH : len_reg;
    k = (k_reg < 1) ? 1 : (k_reg > MAX_RESULTS) ? MAX_RESULTS : k_reg;
    if (it.op != in_query) begin
      coord_pos = 0;
      in_query = it.op;
    end
    pos = coord_pos;
    if (it.op == OP_ADD) begin
      if (n_entries < MAX_ENTRIES && pos < len)
        row_mem[n_entries*MAX_LENGTH + pos] = it.coord;
      if (pos < len) pos++;
      if (!it.last) begin
        coord_pos = pos;
        return;
      end
      coord_pos = 0;
      if (n_entries < MAX_ENTRIES) begin
        for (int i = pos; i < MAX_LENGTH; i++) row_mem[n_entries*MAX_LENGTH + i] = '0;
        id_mem[n_entries] = it.chunk;
        tag_mem[n_entries] = it.tag;
        n_entries++;
      end
      return;
    end
    if (pos < len) qvec[pos] = it.coord;
    if (pos < len) pos++;
    if (!it.last) begin
      coord_pos = pos;
      return;
    end
    coord_pos = 0;
    for (int i = pos; i < MAX_LENGTH; i++) qvec[i] = '0;
    n = 0;
    for (int unsigned e = 0; e < n_entries; e++) begin
      if (it.scoped && tag_mem[e] != it.tag) continue;
      base = e * MAX_LENGTH;
      // time term enters negated
      acc = -(longint'(qvec[0]) * longint'(row_mem[base]));
      for (int j = 1; j < len; j++)
        acc = sat_sum(acc, longint'(qvec[j]) * longint'(row_mem[base + j]));
      p = 0;
      while (p < n && best_s[p] >= acc) p++;
      if (p >= k) continue;
      m = (n < k) ? n : k - 1;
      while (m > p) begin
        best_s[m] = best_s[m-1];
        best_i[m] = best_i[m-1];
        m--;
      end
      best_s[p] = acc;
      best_i[p] = e;
      if (n < k) n++;
    end
    if (n == 0) begin
      res = {res, EMPTY_ANS};
      return;
    end
    for (int i = 0; i < n; i++) begin
      a.found = 1'b1;
      a.chunk = id_mem[best_i[i]];
      a.tag = tag_mem[best_i[i]];
      a.score = best_s[i];
      a.last = (i + 1 == n);
      res = {res, a};
    end
  endfunction

  // hold start until the transfer, then predict
  task automatic send(input item_t it, input logic typed = 1'b0,
                      input answer_t ans = NO_ANS);
    answer_t res[$];
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= it.op;
    in_coordinate <= it.coord;
    in_last_coordinate <= it.last;
    in_chunk_id <= it.chunk;
    in_scope_tag <= it.tag;
    in_scope_enable <= it.scoped;
    do @(posedge clk); while (busy);
    n_items++;
    if (it.op == OP_QUERY && it.last) n_queries++;
    rank_query(it, res);
    if (typed) pending_q = {pending_q, ans};
    else foreach (res[i]) pending_q = {pending_q, res[i]};
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_VECTOR_LENGTH) len_reg = val;
    else k_reg = val[4:0];
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 1 << 18) - (1 << 17);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(1) ? 32'h0001_0000 : 32'h0000_0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_tag();
    return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
  endfunction

  task automatic send_vector(input logic op, input int n);
    item_t it;
    it.op = op;
    it.chunk = 31'($urandom);
    it.tag = pick_tag();
    it.scoped = 1'($urandom_range(1));
    for (int i = 0; i < n; i++) begin
      it.coord = pick_coord();
      it.last = (i == n - 1);
      send(it);
    end
  endtask

  // well-formed vectors mostly, some short, long or abandoned
  task automatic random_phase(input int budget);
    int len, n, stop;
    logic op;
    len = (len_reg < 2) ? 2 : (len_reg > MAX_LENGTH) ? MAX_LENGTH : len_reg;
    stop = n_items + budget;
    while (n_items < stop) begin
      op = ($urandom_range(9) < 3) ? OP_QUERY : OP_ADD;
      case ($urandom_range(9))
        0: n = $urandom_range(1, len);
        1: n = len + $urandom_range(1, 3);
        default: n = len;
      endcase
      if ($urandom_range(9) == 0) begin
        item_t junk;
        junk = '{~op, pick_coord(), 1'b0, 31'($urandom), pick_tag(), 1'b1};
        send(junk);
      end
      send_vector(op, n);
    end
  endtask

  row_t dir_tab[] = '{
    // query on an empty store
    '{'{OP_QUERY, 32'h0001_0000, 1'b1, 31'd0, 16'd0, 1'b0}, 1'b1, EMPTY_ANS},
    '{'{OP_ADD, 32'h7FFF_FFFF, 1'b0, 31'd9, 16'd9, 1'b1}, 1'b0, NO_ANS},
    '{'{OP_ADD, 32'h8000_0000, 1'b0, 31'd9, 16'd9, 1'b0}, 1'b0, NO_ANS},
    '{'{OP_ADD, 32'h0000_0000, 1'b1, 31'h7FFF_FFFF, 16'hFFFF, 1'b0}, 1'b0, NO_ANS},
    '{'{OP_ADD, 32'h8000_0000, 1'b1, 31'd0, 16'd0, 1'b0}, 1'b0, NO_ANS},
    // abandoned partial query, then two equal vectors for a tie
    '{'{OP_QUERY, 32'h1234_5678, 1'b0, 31'd0, 16'd0, 1'b1}, 1'b0, NO_ANS},
    '{'{OP_ADD, 32'h0001_0000, 1'b1, 31'd5, 16'd1, 1'b0}, 1'b0, NO_ANS},
    '{'{OP_ADD, 32'h0001_0000, 1'b1, 31'd6, 16'd1, 1'b0}, 1'b0, NO_ANS},
    // extreme query drives the sum close to full scale
    '{'{OP_QUERY, 32'h8000_0000, 1'b0, 31'd0, 16'd0, 1'b0}, 1'b0, NO_ANS},
    '{'{OP_QUERY, 32'h8000_0000, 1'b1, 31'd0, 16'd0, 1'b0}, 1'b0, NO_ANS},
    '{'{OP_QUERY, 32'h7FFF_FFFF, 1'b0, 31'd0, 16'hFFFF, 1'b1}, 1'b0, NO_ANS},
    '{'{OP_QUERY, 32'hFFFF_0000, 1'b1, 31'd0, 16'hFFFF, 1'b1}, 1'b0, NO_ANS},
    '{'{OP_QUERY, 32'h0001_0000, 1'b1, 31'd0, 16'd1, 1'b1}, 1'b0, NO_ANS},
    // every entry filtered out
    '{'{OP_QUERY, 32'h0001_0000, 1'b1, 31'd0, 16'h1234, 1'b1}, 1'b1, EMPTY_ANS}
  };

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      n_answers++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result chunk %h score %h", $time,
                 out_result_chunk_id, out_score);
      end else begin
        want = pending_q.pop_front();
        if (out_found !== want.found) begin
          errors++;
          $display("%0t: found exp %b got %b", $time, want.found, out_found);
        end
        if (out_result_chunk_id !== want.chunk) begin
          errors++;
          $display("%0t: chunk exp %h got %h", $time, want.chunk, out_result_chunk_id);
        end
        if (out_result_tag !== want.tag) begin
          errors++;
          $display("%0t: tag exp %h got %h", $time, want.tag, out_result_tag);
        end
        if (out_score !== want.score) begin
          errors++;
          $display("%0t: score exp %h got %h", $time, want.score, out_score);
        end
        if (out_last_result !== want.last) begin
          errors++;
          $display("%0t: last exp %b got %b", $time, want.last, out_last_result);
        end
      end
    end
  end

  // count cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid || !rst_n) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("watchdog expired with %0d results pending", pending_q.size());
      $display("lorentz_inner_product_top_k_search verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) send(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].ans);
    settle();
    // phases: {vector_length, result_count}, clamped values among them
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 13 : (ph < 4) ? 71 : 0;
      case (ph)
        0: begin write_reg(REG_VECTOR_LENGTH, 7'd0);   write_reg(REG_RESULT_COUNT, 7'd0);  end
        1: begin write_reg(REG_VECTOR_LENGTH, 7'd4);   write_reg(REG_RESULT_COUNT, 7'd3);  end
        2: begin write_reg(REG_VECTOR_LENGTH, 7'd127); write_reg(REG_RESULT_COUNT, 7'd31); end
        3: begin write_reg(REG_VECTOR_LENGTH, 7'd1);   write_reg(REG_RESULT_COUNT, 7'd16); end
        4: begin write_reg(REG_VECTOR_LENGTH, 7'd3);   write_reg(REG_RESULT_COUNT, 7'd1);  end
        default: begin write_reg(REG_VECTOR_LENGTH, 7'd2); write_reg(REG_RESULT_COUNT, 7'd17); end
      endcase
      random_phase(ph == 2 ? 40 : 18);
      settle();
    end
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d items, %0d queries, %0d results checked", n_items, n_queries,
             n_answers);
    $display("store reached %0d entries; six register settings", n_entries);
    if (errors == 0)
      $display("lorentz_inner_product_top_k_search verification clean");
    else
      $display("lorentz_inner_product_top_k_search verification failed");
    $finish;
  end
endmodule
